// ===== design/envelope_level_detector_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ENVELOPE_LEVEL_DETECTOR_CORE_DEFINES_SVH
`define ENVELOPE_LEVEL_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ELD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ELD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/eld_pkg.sv =====
package eld_pkg;

    // Data formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int MODE_BITS   = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_IDX_W   = 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 2'd2;

    // Detector topologies
    localparam logic [MODE_BITS-1:0] MODE_NONCORR    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_BRANCH     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DECOUP     = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_BR_SMOOTH  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_DEC_SMOOTH = 3'd4;

    // Coefficient reset values
    localparam logic [COEF_BITS-1:0] ATTACK_RESET  = 24'd16000000;
    localparam logic [COEF_BITS-1:0] RELEASE_RESET = 24'd16700000;

    // Multiplier operand selects
    typedef enum logic [1:0] {
        OPND_Y,
        OPND_Y1,
        OPND_T
    } t_opnd_sel;

    typedef enum logic [1:0] {
        COEF_A,
        COEF_R,
        COEF_NA,
        COEF_NR
    } t_coef_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_in;
        logic      prep;
        logic      prep_diff;
        logic      mul_en;
        t_opnd_sel opnd_sel;
        t_coef_sel coef_sel;
        logic      acc_load;
        logic      acc_add;
        logic      stage_max;
        logic      fin;
        logic      clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic up;
        logic out_free;
    } t_status;

endpackage

// ===== design/envelope_level_detector_core.sv =====
// Peak level detector with attack and release smoothing for a dynamics
// compressor. Each input transfer carries one signed Q1.23 sample, or a clear
// request that zeroes the detector state and returns level 0; every input
// transfer yields exactly one output transfer. The topology comes from
// detector_mode (APB offset 0x0): 0 non-corrected, 1 branching, 2 decoupled,
// 3 branching smooth, 4 decoupled smooth; codes 5 to 7 act as branching.
// attack_coef (0x4) and release_coef (0x8) are unsigned Q0.24 coefficients
// computed by software; write them only while the block is idle. The work on a
// sample is set by the number of products that pass in turn through the one
// shared multiplier, which depends on the topology; a clear uses no product.
// The input is ready again in the cycle after the result is registered.
// A finished result waits in an output register while the next item is
// accepted.
module envelope_level_detector_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_req_type,
    input  logic signed [eld_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [eld_pkg::SAMPLE_BITS-1:0] o_level_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [eld_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [eld_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [eld_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import eld_pkg::*;

    logic [MODE_BITS-1:0] r_mode;
    logic [COEF_BITS-1:0] r_attack;
    logic [COEF_BITS-1:0] r_release;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    t_cmd                 cmd;
    t_status              status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_BRANCH;
            r_attack  <= ATTACK_RESET;
            r_release <= RELEASE_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_MODE:    r_mode    <= pwdata[MODE_BITS-1:0];
                REG_ATTACK:  r_attack  <= pwdata[COEF_BITS-1:0];
                REG_RELEASE: r_release <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_MODE:    prdata = APB_DATA_W'(r_mode);
            REG_ATTACK:  prdata = APB_DATA_W'(r_attack);
            REG_RELEASE: prdata = APB_DATA_W'(r_release);
            default:     prdata = '0;
        endcase
    end

    eld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eld_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_attack_coef  (r_attack),
        .i_release_coef (r_release),
        .i_sample_in    (i_sample_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_level_out    (o_level_out)
    );

endmodule

// ===== design/eld_ctrl.sv =====
module eld_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [eld_pkg::MODE_BITS-1:0]   i_mode,
    input  logic                            i_in_valid,
    input  logic                            i_req_type,
    output logic                            o_in_ready,
    input  eld_pkg::t_status                i_status,
    output eld_pkg::t_cmd                   o_cmd
);
    import eld_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_S1_MUL,
        ST_S1_ACC,
        ST_S1_ACC2,
        ST_S1_MAX,
        ST_S2_MUL,
        ST_S2_ACC,
        ST_S2_ACC2,
        ST_S2_FIN,
        ST_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_dec;
    logic   is_br_smooth;

    // Decode topology
    always_comb begin
        is_dec       = i_mode inside {MODE_DECOUP, MODE_DEC_SMOOTH};
        is_br_smooth = (i_mode == MODE_BR_SMOOTH);
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Sequence the shared multiplier
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.opnd_sel = OPND_Y;
        o_cmd.coef_sel = COEF_A;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_req_type ? ST_CLEAR : ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep      = 1'b1;
                o_cmd.prep_diff = (i_mode == MODE_NONCORR);
                n_state = is_dec ? ST_S1_MUL : ST_S2_MUL;
            end
            ST_S1_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.opnd_sel = OPND_Y1;
                o_cmd.coef_sel = COEF_R;
                n_state = ST_S1_ACC;
            end
            ST_S1_ACC: begin
                o_cmd.acc_load = 1'b1;
                if (i_mode == MODE_DEC_SMOOTH) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.opnd_sel = OPND_T;
                    o_cmd.coef_sel = COEF_NR;
                    n_state = ST_S1_ACC2;
                end else begin
                    n_state = ST_S1_MAX;
                end
            end
            ST_S1_ACC2: begin
                o_cmd.acc_add = 1'b1;
                n_state = ST_S1_MAX;
            end
            ST_S1_MAX: begin
                o_cmd.stage_max = 1'b1;
                n_state = ST_S2_MUL;
            end
            ST_S2_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.opnd_sel = OPND_Y;
                if (i_mode == MODE_NONCORR) begin
                    o_cmd.coef_sel = COEF_R;
                end else if (is_dec || i_status.up) begin
                    o_cmd.coef_sel = COEF_A;
                end else begin
                    o_cmd.coef_sel = COEF_R;
                end
                n_state = ST_S2_ACC;
            end
            ST_S2_ACC: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.opnd_sel = OPND_T;
                if (i_mode == MODE_NONCORR || is_dec || i_status.up) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.coef_sel = COEF_NA;
                    n_state = ST_S2_ACC2;
                end else if (is_br_smooth) begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.coef_sel = COEF_NR;
                    n_state = ST_S2_ACC2;
                end else begin
                    n_state = ST_S2_FIN;
                end
            end
            ST_S2_ACC2: begin
                o_cmd.acc_add = 1'b1;
                n_state = ST_S2_FIN;
            end
            ST_S2_FIN: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (i_status.out_free) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/eld_datapath.sv =====
module eld_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  eld_pkg::t_cmd                          i_cmd,
    output eld_pkg::t_status                       o_status,
    input  logic [eld_pkg::COEF_BITS-1:0]          i_attack_coef,
    input  logic [eld_pkg::COEF_BITS-1:0]          i_release_coef,
    input  logic signed [eld_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [eld_pkg::SAMPLE_BITS-1:0] o_level_out
);
    import eld_pkg::*;

    localparam int OPND_W  = SAMPLE_BITS + 1;
    localparam int COEFX_W = COEF_BITS + 2;
    localparam int PROD_W  = OPND_W + COEFX_W;
    localparam int ACC_W   = PROD_W - COEF_BITS;

    localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (COEF_BITS - 1);
    localparam logic signed [COEFX_W-1:0] COEF_ONE   = COEFX_W'(1) << COEF_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_level(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SAT_HI) begin
            res = SAMPLE_MAX;
        end else if (v < SAT_LO) begin
            res = SAMPLE_MIN;
        end else begin
            res = signed'(v[SAMPLE_BITS-1:0]);
        end
        return res;
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [OPND_W-1:0]      r_t;
    logic                          r_up;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_level;

    logic signed [OPND_W-1:0]      x_ext;
    logic signed [OPND_W-1:0]      y_ext;
    logic signed [OPND_W-1:0]      diff;
    logic signed [OPND_W-1:0]      opnd;
    logic signed [COEFX_W-1:0]     coef;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [SAMPLE_BITS-1:0] acc_sat;
    logic signed [SAMPLE_BITS-1:0] stage_t;

    // Operand and coefficient selection
    always_comb begin
        x_ext = OPND_W'(r_x);
        y_ext = OPND_W'(r_y);
        diff  = x_ext - y_ext;
        case (i_cmd.opnd_sel)
            OPND_Y:  opnd = y_ext;
            OPND_Y1: opnd = OPND_W'(r_y1);
            OPND_T:  opnd = r_t;
            default: opnd = r_t;
        endcase
        case (i_cmd.coef_sel)
            COEF_A:  coef = signed'({2'b00, i_attack_coef});
            COEF_R:  coef = signed'({2'b00, i_release_coef});
            COEF_NA: coef = COEF_ONE - signed'({2'b00, i_attack_coef});
            COEF_NR: coef = COEF_ONE - signed'({2'b00, i_release_coef});
            default: coef = COEF_ONE;
        endcase
        rnd     = signed'(r_prod[COEF_BITS +: ACC_W]);
        acc_sat = sat_level(r_acc);
        stage_t = (r_x > acc_sat) ? r_x : acc_sat;
    end

    // Input load, operand prep, multiply, round, accumulate and result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.prep) begin
            r_up <= (r_x > r_y);
            if (i_cmd.prep_diff) begin
                r_t <= diff[OPND_W-1] ? '0 : diff;
            end else begin
                r_t <= x_ext;
            end
        end else if (i_cmd.stage_max) begin
            r_t <= OPND_W'(stage_t);
        end
        if (i_cmd.mul_en) begin
            r_prod <= opnd * coef + ROUND_HALF;
        end
        if (i_cmd.acc_load) begin
            r_acc <= rnd;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + rnd;
        end
        if (i_cmd.fin) begin
            r_level <= acc_sat;
        end else if (i_cmd.clear) begin
            r_level <= '0;
        end
    end

    // Detector state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y         <= '0;
            r_y1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_y  <= '0;
                r_y1 <= '0;
            end else begin
                if (i_cmd.fin) begin
                    r_y <= acc_sat;
                end
                if (i_cmd.stage_max) begin
                    r_y1 <= stage_t;
                end
            end
            if (i_cmd.fin || i_cmd.clear) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.up       = r_up;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_level_out       = r_level;

endmodule

// ===== design/eld_checker.sv =====
`include "envelope_level_detector_core_defines.svh"

module eld_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   i_req_type,
    input logic signed [eld_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [eld_pkg::SAMPLE_BITS-1:0] o_level_out,
    input logic                                   psel,
    input logic                                   penable,
    input logic                                   pwrite,
    input logic [eld_pkg::APB_ADDR_W-1:0]         paddr,
    input logic [eld_pkg::APB_DATA_W-1:0]         pwdata,
    input logic [eld_pkg::APB_DATA_W-1:0]         prdata,
    input logic                                   pready
);
    import eld_pkg::*;

    // The APB port never inserts wait states
    `ELD_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

    // An accepted item leaves the input not ready in the cycle after the transfer
    `ELD_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "input taken again right after a transfer")

    // A stalled result holds its value
    `ELD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_level_out), "stalled result changed or dropped")

    // A clear with an empty output register passes the clear state, then shows a valid level 0
    `ELD_ASSERT_NOW(a_clear_zero,
        i_in_valid && o_in_ready && i_req_type && !o_out_valid,
        ##2 (o_out_valid && o_level_out == '0), "clear did not return level 0")

endmodule

bind envelope_level_detector_core eld_checker u_eld_checker (.*);
